[sv/lpat_pkg.sv]
// Shared types, codes and helpers for the longest-prefix action table.
`timescale 1ns / 1ps
package lpat_pkg;

   localparam int ENTRIES    = 64;
   localparam int IFACES     = 4;
   localparam int HW_BYTES   = 8;
   localparam int MAX_PREFIX = 32;
   localparam int IDX_W      = $clog2(ENTRIES);

   localparam logic [63:0] HW_MASK = {64{1'b1}} >> (64 - 8 * HW_BYTES);

   typedef enum logic [1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_INSERT = 2'd1,
      KIND_LOOKUP = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   localparam logic [1:0] ACT_IGNORE   = 2'd0;
   localparam logic [2:0] SCOPE_GLOBAL = 3'd0;

   typedef struct packed {
      logic [2:0]  scope;
      logic [31:0] prefix;
      logic [5:0]  plen;
      logic [1:0]  action;
      logic [63:0] hw;
      logic [3:0]  hwlen;
   } entry_type;

   typedef struct packed {
      logic [31:0] ip;
      logic [31:0] pfx;
      logic [5:0]  plen;
      logic [2:0]  scope;
      logic        iface_ok;
   } key_type;

   typedef struct packed {
      logic dup_hit;
      logic iface_hit;
      logic global_hit;
   } cmp_type;

   function automatic logic [31:0] len_to_mask(input logic [5:0] len);
      return ~(32'hFFFF_FFFF >> len);
   endfunction

endpackage

[sv/longest_prefix_action_table_unit.sv]
// Top level of the longest-prefix action table: sequencer, slot scan and result register.
//
//   channel   | handshake              | fields
//   ----------+------------------------+---------------------------------------------
//   request   | start, busy            | req_kind, req_ip_address, req_prefix_len,
//             |                        | req_scope, req_action_code, req_hw_address,
//             |                        | req_hw_length
//   response  | rsp_valid (1 cycle)    | rsp_status, rsp_hit, rsp_result_action,
//             |                        | rsp_result_hw_address, rsp_result_hw_length,
//             |                        | rsp_matched_len
//
// Insert and lookup scan all slots, reading one slot per cycle from the single-read table
// RAM through one shared compare unit; an insert with scope above IFACES skips the scan.
// Clear and the unused kind respond in the cycle after accept.
// Synchronous reset empties the table at once through the valid flops.
// The response cannot be stalled; busy stays high until the response strobe is raised.
`timescale 1ns / 1ps
module longest_prefix_action_table_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_ip_address,
   input  logic [5:0]  req_prefix_len,
   input  logic [2:0]  req_scope,
   input  logic [1:0]  req_action_code,
   input  logic [63:0] req_hw_address,
   input  logic [3:0]  req_hw_length,
   output logic        rsp_valid,
   output logic        rsp_status,
   output logic        rsp_hit,
   output logic [1:0]  rsp_result_action,
   output logic [63:0] rsp_result_hw_address,
   output logic [3:0]  rsp_result_hw_length,
   output logic [5:0]  rsp_matched_len
);
   import lpat_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_FINAL = 4'b1000
   } state_type;

   typedef struct packed {
      logic        found;
      logic [5:0]  plen;
      logic [1:0]  action;
      logic [63:0] hw;
      logic [3:0]  hwlen;
   } best_type;

   state_type        state_ff, state_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic             pend_ff, pend_in;
   kind_type         kind_ff, kind_in;
   key_type          key_ff, key_in;
   logic [1:0]       act_ff, act_in;
   logic [63:0]      hw_ff, hw_in;
   logic [3:0]       hwlen_ff, hwlen_in;
   best_type         iface_ff, iface_in, glob_ff, glob_in;
   logic             dup_ff, dup_in, free_ff, free_in;
   logic [IDX_W-1:0] dup_idx_ff, dup_idx_in, free_idx_ff, free_idx_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_status_ff, rsp_status_in;
   logic             rsp_hit_ff, rsp_hit_in;
   logic [1:0]       rsp_action_ff, rsp_action_in;
   logic [63:0]      rsp_hw_ff, rsp_hw_in;
   logic [3:0]       rsp_hwlen_ff, rsp_hwlen_in;
   logic [5:0]       rsp_len_ff, rsp_len_in;

   logic             accept;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data, rd_data;
   cmp_type          cmp;
   best_type         sel;
   logic [5:0]       plen_c;
   logic [3:0]       hwlen_c;

   lpat_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   lpat_cmp u_cmp (
      .valid  (pend_ff && valid_ff[rd_idx_ff]),
      .entry  (rd_data),
      .key    (key_ff),
      .result (cmp)
   );

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      addr_in       = addr_ff;
      rd_idx_in     = rd_idx_ff;
      pend_in       = 1'b0;
      kind_in       = kind_ff;
      key_in        = key_ff;
      act_in        = act_ff;
      hw_in         = hw_ff;
      hwlen_in      = hwlen_ff;
      iface_in      = iface_ff;
      glob_in       = glob_ff;
      dup_in        = dup_ff;
      dup_idx_in    = dup_idx_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_action_in = rsp_action_ff;
      rsp_hw_in     = rsp_hw_ff;
      rsp_hwlen_in  = rsp_hwlen_ff;
      rsp_len_in    = rsp_len_ff;
      wr_en         = 1'b0;
      wr_addr       = dup_ff ? dup_idx_ff : free_idx_ff;
      wr_data       = '{scope: key_ff.scope, prefix: key_ff.pfx, plen: key_ff.plen,
                        action: act_ff, hw: hw_ff, hwlen: hwlen_ff};
      sel           = iface_ff.found ? iface_ff : glob_ff;
      plen_c        = (req_prefix_len > 6'(MAX_PREFIX)) ? 6'(MAX_PREFIX) : req_prefix_len;
      hwlen_c       = (req_hw_length > 4'(HW_BYTES)) ? 4'(HW_BYTES) : req_hw_length;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in        = kind_type'(req_kind);
               key_in.ip      = req_ip_address;
               key_in.pfx     = req_ip_address & len_to_mask(plen_c);
               key_in.plen    = plen_c;
               key_in.scope   = req_scope;
               key_in.iface_ok = (req_scope != SCOPE_GLOBAL) && (req_scope <= 3'(IFACES));
               act_in         = req_action_code;
               hwlen_in       = hwlen_c;
               hw_in          = (hwlen_c == 4'd0) ? 64'd0 : (req_hw_address & HW_MASK);
               iface_in       = '0;
               glob_in        = '0;
               dup_in         = 1'b0;
               free_in        = 1'b0;
               addr_in        = '0;
               rsp_status_in  = 1'b0;
               rsp_hit_in     = 1'b0;
               rsp_action_in  = ACT_IGNORE;
               rsp_hw_in      = '0;
               rsp_hwlen_in   = '0;
               rsp_len_in     = '0;
               case (kind_type'(req_kind))
                  KIND_CLEAR: begin
                     valid_in     = '0;
                     rsp_valid_in = 1'b1;
                  end
                  KIND_INSERT: begin
                     if (req_scope > 3'(IFACES)) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  KIND_LOOKUP: begin
                     state_in = ST_SCAN;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            pend_in   = 1'b1;
            rd_idx_in = addr_ff;
            if (addr_ff == IDX_W'(ENTRIES - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINAL;
         end
         ST_FINAL: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            if (kind_ff == KIND_INSERT) begin
               if (dup_ff || free_ff) begin
                  wr_en             = 1'b1;
                  valid_in[wr_addr] = 1'b1;
               end else begin
                  rsp_status_in = 1'b1;
               end
            end else begin
               rsp_hit_in    = sel.found;
               rsp_action_in = sel.action;
               rsp_len_in    = sel.plen;
               if (sel.action != ACT_IGNORE) begin
                  rsp_hw_in    = sel.hw;
                  rsp_hwlen_in = sel.hwlen;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (pend_ff) begin
         if (cmp.dup_hit && !dup_ff) begin
            dup_in     = 1'b1;
            dup_idx_in = rd_idx_ff;
         end
         if (!valid_ff[rd_idx_ff] && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = rd_idx_ff;
         end
         if (cmp.iface_hit && (!iface_ff.found || rd_data.plen > iface_ff.plen)) begin
            iface_in = '{found: 1'b1, plen: rd_data.plen, action: rd_data.action,
                         hw: rd_data.hw, hwlen: rd_data.hwlen};
         end
         if (cmp.global_hit && (!glob_ff.found || rd_data.plen > glob_ff.plen)) begin
            glob_in = '{found: 1'b1, plen: rd_data.plen, action: rd_data.action,
                        hw: rd_data.hw, hwlen: rd_data.hwlen};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      rd_idx_ff     <= rd_idx_in;
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      act_ff        <= act_in;
      hw_ff         <= hw_in;
      hwlen_ff      <= hwlen_in;
      iface_ff      <= iface_in;
      glob_ff       <= glob_in;
      dup_ff        <= dup_in;
      dup_idx_ff    <= dup_idx_in;
      free_ff       <= free_in;
      free_idx_ff   <= free_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_action_ff <= rsp_action_in;
      rsp_hw_ff     <= rsp_hw_in;
      rsp_hwlen_ff  <= rsp_hwlen_in;
      rsp_len_ff    <= rsp_len_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_hit               = rsp_hit_ff;
   assign rsp_result_action     = rsp_action_ff;
   assign rsp_result_hw_address = rsp_hw_ff;
   assign rsp_result_hw_length  = rsp_hwlen_ff;
   assign rsp_matched_len       = rsp_len_ff;

`ifndef NO_ASSERTIONS
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe raised while busy");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_valid))
      else $error("accepted transaction neither busy nor answered");

   a_write_final: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_FINAL) && (kind_ff == KIND_INSERT))
      else $error("table write outside insert completion");

   a_status_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_status && rsp_hit))
      else $error("full status and hit reported together");

   a_scan_to_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> $past(addr_ff) == IDX_W'(ENTRIES - 1))
      else $error("scan ended before the last slot");
`endif

endmodule

[sv/lpat_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lpat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/lpat_cmp.sv]
// Shared entry compare unit: prefix match per scope and duplicate detection.
`timescale 1ns / 1ps
module lpat_cmp (
   input  logic               valid,
   input  lpat_pkg::entry_type entry,
   input  lpat_pkg::key_type  key,
   output lpat_pkg::cmp_type  result
);
   import lpat_pkg::*;

   logic pfx_match;

   always_comb begin
      pfx_match = ((key.ip & len_to_mask(entry.plen)) == entry.prefix);
      result.dup_hit = valid && (entry.scope == key.scope) &&
                       (entry.plen == key.plen) && (entry.prefix == key.pfx);
      result.iface_hit = valid && pfx_match && key.iface_ok &&
                         (entry.scope == key.scope);
      result.global_hit = valid && pfx_match && (entry.scope == SCOPE_GLOBAL);
   end

endmodule

[verif/testbench.sv]
// Self-checking testbench for the longest-prefix action table unit.
`timescale 1ns / 1ps
module testbench;
   import lpat_pkg::*;

   typedef struct packed {
      logic        status;
      logic        hit;
      logic [1:0]  action;
      logic [63:0] hw;
      logic [3:0]  hwlen;
      logic [5:0]  mlen;
   } table_answer_type;

   class action_table_scoreboard;
      bit               slot_valid[ENTRIES];
      logic [2:0]       slot_scope[ENTRIES];
      logic [31:0]      slot_prefix[ENTRIES];
      int               slot_len[ENTRIES];
      logic [1:0]       slot_action[ENTRIES];
      logic [63:0]      slot_hw[ENTRIES];
      int               slot_hwlen[ENTRIES];
      table_answer_type expected_answers[$];
      int               failures;

      function new();
         for (int i = 0; i < ENTRIES; i++) slot_valid[i] = 1'b0;
         failures = 0;
      endfunction

      static function logic [31:0] net_mask(int len);
         if (len <= 0) return 32'd0;
         if (len >= 32) return 32'hFFFF_FFFF;
         return 32'hFFFF_FFFF << (32 - len);
      endfunction

      function int longest_match(logic [2:0] sc, logic [31:0] ip);
         int found;
         found = -1;
         for (int i = 0; i < ENTRIES; i++) begin
            if (slot_valid[i] && slot_scope[i] == sc &&
                (ip & net_mask(slot_len[i])) == slot_prefix[i]) begin
               if (found < 0 || slot_len[i] > slot_len[found]) found = i;
            end
         end
         return found;
      endfunction

      function int pending();
         return expected_answers.size();
      endfunction

      function void note_request(kind_type k, logic [31:0] ip, logic [5:0] plen_in,
                                 logic [2:0] sc, logic [1:0] act, logic [63:0] hw_in,
                                 logic [3:0] hwlen_in);
         table_answer_type a;
         int               plen;
         int               hwlen;
         logic [63:0]      hw;
         logic [31:0]      pfx;
         int               slot;
         int               free_slot;
         int               m;
         a = '0;
         plen = (plen_in > MAX_PREFIX) ? MAX_PREFIX : plen_in;
         hwlen = (hwlen_in > HW_BYTES) ? HW_BYTES : hwlen_in;
         hw = (hwlen == 0) ? 64'd0 : (hw_in & HW_MASK);
         case (k)
            KIND_CLEAR: begin
               for (int i = 0; i < ENTRIES; i++) slot_valid[i] = 1'b0;
            end
            KIND_INSERT: begin
               if (sc <= IFACES) begin
                  pfx = ip & net_mask(plen);
                  slot = -1;
                  free_slot = -1;
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (slot_valid[i]) begin
                        if (slot < 0 && slot_scope[i] == sc && slot_len[i] == plen &&
                            slot_prefix[i] == pfx)
                           slot = i;
                     end else if (free_slot < 0) begin
                        free_slot = i;
                     end
                  end
                  if (slot < 0) slot = free_slot;
                  if (slot < 0) begin
                     a.status = 1'b1;
                  end else begin
                     slot_valid[slot]  = 1'b1;
                     slot_scope[slot]  = sc;
                     slot_prefix[slot] = pfx;
                     slot_len[slot]    = plen;
                     slot_action[slot] = act;
                     slot_hw[slot]     = hw;
                     slot_hwlen[slot]  = hwlen;
                  end
               end
            end
            KIND_LOOKUP: begin
               m = -1;
               if (sc >= 1 && sc <= IFACES) m = longest_match(sc, ip);
               if (m < 0) m = longest_match(SCOPE_GLOBAL, ip);
               if (m >= 0) begin
                  a.hit = 1'b1;
                  a.action = slot_action[m];
                  if (slot_action[m] != ACT_IGNORE) begin
                     a.hw = slot_hw[m];
                     a.hwlen = 4'(slot_hwlen[m]);
                  end
                  a.mlen = 6'(slot_len[m]);
               end
            end
            default: ;
         endcase
         expected_answers.push_back(a);
      endfunction

      function void compare_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
         if (exp_val !== act_val) begin
            failures++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val,
                     act_val);
         end
      endfunction

      function void check_response(logic status, logic hit, logic [1:0] action,
                                   logic [63:0] hw, logic [3:0] hwlen, logic [5:0] mlen);
         table_answer_type e;
         if (expected_answers.size() == 0) begin
            failures++;
            $display("%0t: unexpected response, expected none, actual status %0h hit %0h",
                     $time, status, hit);
            return;
         end
         e = expected_answers.pop_front();
         compare_field("status", 64'(e.status), 64'(status));
         compare_field("hit", 64'(e.hit), 64'(hit));
         compare_field("result_action", 64'(e.action), 64'(action));
         compare_field("result_hw_address", e.hw, hw);
         compare_field("result_hw_length", 64'(e.hwlen), 64'(hwlen));
         compare_field("matched_len", 64'(e.mlen), 64'(mlen));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_kind;
   logic [31:0] req_ip_address;
   logic [5:0]  req_prefix_len;
   logic [2:0]  req_scope;
   logic [1:0]  req_action_code;
   logic [63:0] req_hw_address;
   logic [3:0]  req_hw_length;
   logic        rsp_valid;
   logic        rsp_status;
   logic        rsp_hit;
   logic [1:0]  rsp_result_action;
   logic [63:0] rsp_result_hw_address;
   logic [3:0]  rsp_result_hw_length;
   logic [5:0]  rsp_matched_len;

   action_table_scoreboard sb;

   logic [31:0] pool_ip[32];
   int          pool_len[32];
   logic [2:0]  pool_scope[32];
   int          pool_count;

   longest_prefix_action_table_unit u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_kind(req_kind),
      .req_ip_address(req_ip_address),
      .req_prefix_len(req_prefix_len),
      .req_scope(req_scope),
      .req_action_code(req_action_code),
      .req_hw_address(req_hw_address),
      .req_hw_length(req_hw_length),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_hit(rsp_hit),
      .rsp_result_action(rsp_result_action),
      .rsp_result_hw_address(rsp_result_hw_address),
      .rsp_result_hw_length(rsp_result_hw_length),
      .rsp_matched_len(rsp_matched_len)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_response(rsp_status, rsp_hit, rsp_result_action, rsp_result_hw_address,
                           rsp_result_hw_length, rsp_matched_len);
      if (!reset && start && !busy)
         sb.note_request(kind_type'(req_kind), req_ip_address, req_prefix_len, req_scope,
                         req_action_code, req_hw_address, req_hw_length);
   end

   task automatic send_item(kind_type k, logic [31:0] ip, logic [5:0] plen, logic [2:0] sc,
                            logic [1:0] act, logic [63:0] hw, logic [3:0] hwlen);
      @(negedge clock);
      start           = 1'b1;
      req_kind        = k;
      req_ip_address  = ip;
      req_prefix_len  = plen;
      req_scope       = sc;
      req_action_code = act;
      req_hw_address  = hw;
      req_hw_length   = hwlen;
      do @(posedge clock); while (busy);
   endtask

   task automatic hold_off(int n);
      if (n > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic drain();
      hold_off(1);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic int next_gap(bit no_idle);
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 40) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 90);
   endfunction

   task automatic send_clear();
      pool_count = 0;
      send_item(KIND_CLEAR, $urandom, 6'($urandom), 3'($urandom), 2'($urandom),
                {$urandom, $urandom}, 4'($urandom));
   endtask

   task automatic random_insert(bit fill);
      logic [31:0] ip;
      int          plen;
      logic [2:0]  sc;
      int          p;
      int          r;
      r = $urandom_range(0, 99);
      p = (pool_count > 0) ? $urandom_range(0, pool_count - 1) : 0;
      if (fill) begin
         ip = $urandom;
         plen = $urandom_range(20, 32);
         sc = 3'($urandom_range(0, IFACES));
      end else if (r < 30 && pool_count > 0) begin
         plen = pool_len[p];
         ip = pool_ip[p] ^ ($urandom & ~action_table_scoreboard::net_mask(plen));
         sc = pool_scope[p];
      end else if (r < 55 && pool_count > 0) begin
         plen = $urandom_range(pool_len[p], 32);
         ip = pool_ip[p] ^ ($urandom & ~action_table_scoreboard::net_mask(pool_len[p]));
         sc = $urandom_range(0, 1) ? pool_scope[p] : 3'($urandom_range(0, IFACES));
      end else begin
         ip = $urandom;
         plen = $urandom_range(0, 32);
         sc = 3'($urandom_range(0, IFACES));
      end
      if ($urandom_range(0, 99) < 8) plen = $urandom_range(33, 63);
      if ($urandom_range(0, 99) < 6) sc = 3'($urandom_range(IFACES + 1, 7));
      if (sc <= IFACES && plen <= 32) begin
         if (pool_count < 32) begin
            p = pool_count;
            pool_count++;
         end else begin
            p = $urandom_range(0, 31);
         end
         pool_ip[p] = ip;
         pool_len[p] = plen;
         pool_scope[p] = sc;
      end
      send_item(KIND_INSERT, ip, 6'(plen), sc, 2'($urandom), {$urandom, $urandom},
                4'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 8)
                                                : $urandom_range(9, 15)));
   endtask

   task automatic random_lookup();
      logic [31:0] ip;
      logic [2:0]  sc;
      int          p;
      if ($urandom_range(0, 99) < 70 && pool_count > 0) begin
         p = $urandom_range(0, pool_count - 1);
         ip = pool_ip[p] ^ ($urandom & ~action_table_scoreboard::net_mask(pool_len[p]));
         if ($urandom_range(0, 99) < 15) ip = ip ^ (32'd1 << $urandom_range(0, 31));
         sc = $urandom_range(0, 1) ? pool_scope[p] : 3'($urandom_range(0, 7));
      end else begin
         ip = $urandom;
         sc = 3'($urandom_range(0, 7));
      end
      send_item(KIND_LOOKUP, ip, 6'($urandom), sc, 2'($urandom), {$urandom, $urandom},
                4'($urandom));
   endtask

   initial begin
      bit fill;
      bit no_idle;
      int r;
      sb = new();
      pool_count      = 0;
      reset           = 1'b1;
      start           = 1'b0;
      req_kind        = KIND_CLEAR;
      req_ip_address  = '0;
      req_prefix_len  = '0;
      req_scope       = '0;
      req_action_code = '0;
      req_hw_address  = '0;
      req_hw_length   = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_item(KIND_LOOKUP, 32'h0A01_0505, 6'd0, 3'd1, 2'd0, 64'd0, 4'd0);
      send_item(KIND_CLEAR, 32'd0, 6'd0, 3'd0, 2'd0, 64'd0, 4'd0);
      send_item(KIND_INSERT, 32'hDEAD_BEEF, 6'd0, 3'd0, 2'd1, 64'h0000_0011_2233_4455,
                4'd6);
      send_item(KIND_INSERT, 32'h0A00_0000, 6'd8, 3'd0, 2'd3, 64'hFFFF_FFFF_FFFF_FFFF,
                4'd8);
      send_item(KIND_INSERT, 32'h0A01_0000, 6'd16, 3'd1, 2'd0, 64'h1234, 4'd2);
      send_item(KIND_INSERT, 32'h0A01_0203, 6'd16, 3'd1, 2'd2, 64'h0102_0304_0506, 4'd6);
      send_item(KIND_INSERT, 32'hFFFF_FFFF, 6'd63, 3'd4, 2'd1, 64'hFFFF_FFFF_FFFF_FFFF,
                4'd15);
      send_item(KIND_INSERT, 32'h0A01_0505, 6'd32, 3'd7, 2'd3, 64'h55, 4'd1);
      send_item(KIND_INSERT, 32'hC0A8_0001, 6'd24, 3'd3, 2'd2, 64'hABCD_EF01, 4'd0);
      send_item(KIND_INSERT, 32'h0000_0000, 6'd0, 3'd2, 2'd0, 64'h77, 4'd1);
      send_item(KIND_LOOKUP, 32'h0A01_0505, 6'd0, 3'd1, 2'd0, 64'd0, 4'd0);
      send_item(KIND_LOOKUP, 32'h0A01_0505, 6'd0, 3'd3, 2'd0, 64'd0, 4'd0);
      send_item(KIND_LOOKUP, 32'h0A01_0505, 6'd0, 3'd0, 2'd0, 64'd0, 4'd0);
      send_item(KIND_LOOKUP, 32'h0A01_0505, 6'd0, 3'd6, 2'd0, 64'd0, 4'd0);
      send_item(KIND_LOOKUP, 32'h0A01_0505, 6'd0, 3'd2, 2'd0, 64'd0, 4'd0);
      send_item(KIND_LOOKUP, 32'hFFFF_FFFF, 6'd0, 3'd4, 2'd0, 64'd0, 4'd0);
      send_item(KIND_LOOKUP, 32'hFFFF_FFFE, 6'd0, 3'd4, 2'd0, 64'd0, 4'd0);
      send_item(KIND_LOOKUP, 32'hC0A8_00FF, 6'd0, 3'd3, 2'd0, 64'd0, 4'd0);
      send_item(KIND_NONE, 32'hFFFF_FFFF, 6'd63, 3'd7, 2'd3, 64'hFFFF_FFFF_FFFF_FFFF,
                4'd15);
      send_item(KIND_CLEAR, 32'd0, 6'd0, 3'd0, 2'd0, 64'd0, 4'd0);
      send_item(KIND_LOOKUP, 32'h0A01_0505, 6'd0, 3'd1, 2'd0, 64'd0, 4'd0);
      drain();

      for (int blk = 0; blk < 13; blk++) begin
         fill = (blk % 4 == 3);
         no_idle = ($urandom_range(0, 3) == 0);
         send_clear();
         for (int i = 1; i < 100; i++) begin
            r = $urandom_range(0, 99);
            if (r < 2)
               send_clear();
            else if (r < 5)
               send_item(KIND_NONE, $urandom, 6'($urandom), 3'($urandom), 2'($urandom),
                         {$urandom, $urandom}, 4'($urandom));
            else if (r < (fill ? 75 : 50))
               random_insert(fill);
            else
               random_lookup();
            if ((blk == 6 && i == 50) || $urandom_range(0, 99) < 3)
               drain();
            else
               hold_off(next_gap(no_idle));
         end
      end

      drain();
      repeat (100) @(posedge clock);
      if (sb.failures == 0)
         $display("longest_prefix_action_table_unit test passed");
      else
         $display("longest_prefix_action_table_unit test failed");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("longest_prefix_action_table_unit test failed");
      $finish;
   end

endmodule
